// File: sv/smf_pkg.sv
// smf_pkg: shared types and constants for the substring match finder
// no dependencies; imported by smf_cell and substring_match_finder_core

package smf_pkg;

   // sizes
   localparam int MAX_PATTERN = 8;
   localparam int POS_BITS    = 16;
   localparam int BYTE_BITS   = 8;
   localparam int LEN_BITS    = 4;
   localparam int SEL_BITS    = $clog2(MAX_PATTERN);
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = MAX_PATTERN * BYTE_BITS;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] RANGE_END_RESET = 16'hFFFF;

   // register map
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PATTERN_BYTES  = 4'd0,
      CSR_PATTERN_LENGTH = 4'd1,
      CSR_RANGE_BEGIN    = 4'd2,
      CSR_RANGE_END      = 4'd3
   } csr_index_type;

   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef byte_type [MAX_PATTERN-1:0] pattern_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic advance;  // a request is taken this cycle
      logic flush;    // last byte of text: clear the window after the shift
   } smf_cell_ctrl_type;

endpackage

// File: sv/smf_cell.sv
// smf_cell: one window cell, holds one recent text byte and compares it
// depends on smf_pkg

module smf_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  smf_pkg::smf_cell_ctrl_type ctrl,
   input  smf_pkg::byte_type          byte_in,
   input  smf_pkg::byte_type          expect_byte,
   input  logic                       active,
   output smf_pkg::byte_type          byte_out,
   output logic                       hit
);
   import smf_pkg::*;

   byte_type byte_ff;
   byte_type byte_in_sel;

   // the byte this cell holds once the shift happens
   assign hit      = !active || (byte_in == expect_byte);
   assign byte_out = byte_ff;

   // shift in from the neighbor, clear at end of text
   always_comb begin
      byte_in_sel = byte_ff;
      if (ctrl.advance) begin
         byte_in_sel = ctrl.flush ? '0 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_sel;
      end
   end

endmodule

// File: sv/substring_match_finder_core.sv
// substring_match_finder_core: streaming search for a configured pattern
// depends on smf_pkg and smf_cell
//
// Usage:
//   Text enters one byte per request on req_text_byte, with req_last_of_text
//   marking the final byte of a text. Each request yields zero or one match
//   on the rsp channel (rsp_match_begin, rsp_match_end, end exclusive).
//   Matches are the leftmost non-overlapping occurrences of the pattern that
//   start at or after range_begin and end at or before range_end.
//   The csr channel writes pattern_bytes (0), pattern_length (1),
//   range_begin (2) and range_end (3); csr_ready is always high. Write the
//   registers only while no request is in flight.
//   A match appears on rsp in the cycle after the request carrying its
//   last byte is taken. Throughput: one request per cycle unless rsp stalls,
//   set by the single shift of the cell row and the one-deep result register.
//   When the receiver stalls with a result pending, req_ready drops until the
//   result is taken; a request is still taken in the cycle the result leaves.
//   Reset clears the window, position and match history, sets range_end to
//   65535 and other config registers to zero. No clearing pass is needed.

module substring_match_finder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_text_byte,
   input  logic                                req_last_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_match_begin,
   output logic [15:0]                         rsp_match_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [smf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import smf_pkg::*;

   // configuration registers
   pattern_type          pattern_ff;
   logic [LEN_BITS-1:0]  length_ff;
   logic [POS_BITS-1:0]  range_begin_ff;
   logic [POS_BITS-1:0]  range_end_ff;

   // text state and result register
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [POS_BITS-1:0]  prev_end_ff, prev_end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]  rsp_begin_ff, rsp_begin_in;
   logic [POS_BITS-1:0]  rsp_end_ff, rsp_end_in;

   smf_cell_ctrl_type    cell_ctrl;
   byte_type             chain_in   [MAX_PATTERN];
   byte_type             chain_out  [MAX_PATTERN];
   byte_type             chain_exp  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] chain_act;
   logic [MAX_PATTERN-1:0] chain_hit;

   logic                 accept;
   logic                 len_ok;
   logic                 pos_ok;
   logic [POS_BITS-1:0]  end_pos;
   logic [POS_BITS-1:0]  len_ext;
   logic [POS_BITS-1:0]  start_pos;
   logic                 match;

   csr_index_type        csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cell_ctrl.advance = accept;
   assign cell_ctrl.flush   = req_last_of_text;

   // row of cells: entry 0 holds the newest byte
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j == 0) begin : g_head
         assign chain_in[j] = req_text_byte;
      end else begin : g_body
         assign chain_in[j] = chain_out[j-1];
      end

      // cell j lines up with pattern byte length-1-j
      always_comb begin
         logic [LEN_BITS-1:0] sel;
         sel          = length_ff - LEN_BITS'(1) - LEN_BITS'(j);
         chain_act[j] = length_ff > LEN_BITS'(j);
         chain_exp[j] = pattern_ff[sel[SEL_BITS-1:0]];
      end

      smf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .byte_in     (chain_in[j]),
         .expect_byte (chain_exp[j]),
         .active      (chain_act[j]),
         .byte_out    (chain_out[j]),
         .hit         (chain_hit[j])
      );
   end

   // position and range qualification
   assign len_ok    = (length_ff != '0) && (length_ff <= LEN_BITS'(MAX_PATTERN));
   assign pos_ok    = (pos_ff != POS_MAX);
   assign end_pos   = pos_ff + POS_BITS'(1);
   assign len_ext   = POS_BITS'(length_ff);
   assign start_pos = end_pos - len_ext;
   assign match     = len_ok && pos_ok && (end_pos >= len_ext)
                      && (start_pos >= range_begin_ff) && (start_pos >= prev_end_ff)
                      && (end_pos <= range_end_ff) && (&chain_hit);

   // next state for position, history and result
   always_comb begin
      pos_in       = pos_ff;
      prev_end_in  = prev_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_begin_in = rsp_begin_ff;
      rsp_end_in   = rsp_end_ff;
      if (accept) begin
         rsp_valid_in = match;
         if (match) begin
            rsp_begin_in = start_pos;
            rsp_end_in   = end_pos;
            prev_end_in  = end_pos;
         end
         if (pos_ok) begin
            pos_in = end_pos;
         end
         if (req_last_of_text) begin
            pos_in      = '0;
            prev_end_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         prev_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         prev_end_ff  <= prev_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_begin_ff <= rsp_begin_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         length_ff      <= '0;
         range_begin_ff <= '0;
         range_end_ff   <= RANGE_END_RESET;
      end else if (csr_valid) begin
         unique case (csr_sel)
            CSR_PATTERN_BYTES:  pattern_ff     <= pattern_type'(csr_data);
            CSR_PATTERN_LENGTH: length_ff      <= csr_data[LEN_BITS-1:0];
            CSR_RANGE_BEGIN:    range_begin_ff <= csr_data[POS_BITS-1:0];
            CSR_RANGE_END:      range_end_ff   <= csr_data[POS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_begin = rsp_begin_ff;
   assign rsp_match_end   = rsp_end_ff;

endmodule
